// ===== design/btlv_pkg.sv =====
// btlv_pkg: shared types and constants of the ber-tlv stream parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package btlv_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_TAG_LONG   = 2'd0;
    localparam logic [1:0] ERR_INDEF_LEN  = 2'd1;
    localparam logic [1:0] ERR_LEN_BYTES  = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

    // encoding constants
    localparam logic [7:0] TAG_ESC_MASK  = 8'h1F;
    localparam logic [7:0] CONS_BIT      = 8'h20;
    localparam logic [7:0] LEN_LONG      = 8'h80;
    localparam logic [7:0] LEN_CNT_MASK  = 8'h7F;
    localparam logic [7:0] PAD_ZERO      = 8'h00;
    localparam logic [7:0] PAD_ONES      = 8'hFF;
    localparam logic [1:0] TAG_CONT_MAX  = 2'd3;
    localparam logic [5:0] MAX_DEPTH_RST = 6'd32;

    // parse phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_TAG   = 3'd2,
        PH_LEN1  = 3'd3,
        PH_LENX  = 3'd4,
        PH_VALUE = 3'd5,
        PH_SKIP  = 3'd6,
        PH_HALT  = 3'd7
    } phase_t;

    // back-end sequencer
    typedef enum logic [1:0] {
        ENG_EXEC     = 2'd0,
        ENG_POP_TEST = 2'd1,
        ENG_POP_WAIT = 2'd2
    } eng_state_t;

    // classified input transaction
    typedef struct packed {
        logic [7:0]  byte_value;
        logic        first;
        logic [31:0] message_length;
        logic        is_pad;
        logic        is_tag_esc;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tag;
        logic        constructed;
        logic [31:0] value_length;
        logic [4:0]  depth;
        logic [7:0]  data_byte;
        logic [1:0]  error_code;
        logic        failed;
        logic        last_of_run;
    } result_t;

endpackage

// ===== design/btlv_front.sv =====
// btlv_front: input queue that accepts and classifies message bytes
// depends on btlv_pkg
`timescale 1ns / 1ps

module btlv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           byte_value,
    input  logic                 first,
    input  logic [31:0]          message_length,
    output logic                 item_valid,
    output btlv_pkg::item_t      item,
    input  logic                 item_take
);
    import btlv_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_take;
    item_t      new_item;

    // classify the byte on entry
    always_comb
    begin
        new_item.byte_value     = byte_value;
        new_item.first          = first;
        new_item.message_length = message_length;
        new_item.is_pad         = (byte_value == PAD_ZERO) || (byte_value == PAD_ONES);
        new_item.is_tag_esc     = (byte_value & TAG_ESC_MASK) == TAG_ESC_MASK;
    end

    assign full       = count_reg == 2'd2;
    assign item_valid = count_reg != 2'd0;
    assign item       = slot_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_take    = item_take && item_valid;

    // pointer and count update
    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_take;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= new_item;
    end

endmodule

// ===== design/btlv_out_queue.sv =====
// btlv_out_queue: result queue taking up to two results a cycle
// depends on btlv_pkg
`timescale 1ns / 1ps

module btlv_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           wr_count,
    input  btlv_pkg::result_t    wr_res0,
    input  btlv_pkg::result_t    wr_res1,
    output logic                 room_for_two,
    output logic                 empty,
    input  logic                 pop,
    output btlv_pkg::result_t    head
);
    import btlv_pkg::*;

    result_t    slot_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg;
    logic       do_pop;

    assign empty        = count_reg == 3'd0;
    assign room_for_two = count_reg <= 3'd2;
    assign head         = slot_reg[rptr_reg];
    assign do_pop       = pop && !empty;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + wr_count;
            rptr_reg  <= rptr_reg + {1'b0, do_pop};
            count_reg <= count_reg + {1'b0, wr_count} - {2'b0, do_pop};
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
            slot_reg[wptr_reg] <= wr_res0;
        if (wr_count == 2'd2)
            slot_reg[wptr_reg + 2'd1] <= wr_res1;
    end

endmodule

// ===== design/btlv_back.sv =====
// btlv_back: parse engine with nesting stack memory
// depends on btlv_pkg; fed by btlv_front, drains into btlv_out_queue
`timescale 1ns / 1ps

module btlv_back #(
    parameter int MAX_NEST         = 32,
    parameter int LENGTH_BYTES_MAX = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [5:0]           max_depth,
    input  logic                 item_valid,
    input  btlv_pkg::item_t      item,
    output logic                 item_take,
    input  logic                 room_for_two,
    output logic [1:0]           wr_count,
    output btlv_pkg::result_t    wr_res0,
    output btlv_pkg::result_t    wr_res1
);
    import btlv_pkg::*;

    localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int NW = $clog2(MAX_NEST + 1);
    localparam int LW = 8 * LENGTH_BYTES_MAX;
    localparam int CW = (LW > 32) ? LW : 32;
    localparam int BW = $clog2(LENGTH_BYTES_MAX + 1);

    eng_state_t     eng_reg, eng_next;
    phase_t         phase_reg, phase_next;
    logic [31:0]    tag_reg, tag_next;
    logic [1:0]     tcnt_reg, tcnt_next;
    logic           cons_reg, cons_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [BW-1:0]  lleft_reg, lleft_next;
    logic [31:0]    pos_reg, pos_next;
    logic [31:0]    total_reg, total_next;
    logic [31:0]    vend_reg, vend_next;
    logic [NW-1:0]  nest_reg, nest_next;
    logic           err_reg, err_next;
    logic [31:0]    top_reg, top_next;

    logic [31:0]    stack_mem [MAX_NEST];
    logic [31:0]    rd_data_reg;
    logic [IW-1:0]  rd_addr;
    logic           st_we;
    logic [IW-1:0]  st_waddr;

    result_t        res [2];
    logic [1:0]     n;

    // byte execution and stack pop sequencing
    always_comb
    begin
        logic [6:0]    depth_lim;
        logic [31:0]   cend;
        logic [31:0]   room;
        logic [6:0]    cnt;
        logic          hdone;
        logic [7:0]    b;
        logic [NW-1:0] nest_dec;

        eng_next   = eng_reg;
        phase_next = phase_reg;
        tag_next   = tag_reg;
        tcnt_next  = tcnt_reg;
        cons_next  = cons_reg;
        len_next   = len_reg;
        lleft_next = lleft_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        vend_next  = vend_reg;
        nest_next  = nest_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        item_take  = 1'b0;
        st_we      = 1'b0;
        st_waddr   = IW'(nest_reg);
        rd_addr    = '0;
        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;
        hdone      = 1'b0;
        b          = item.byte_value;
        cnt        = 7'(b & LEN_CNT_MASK);
        nest_dec   = nest_reg - NW'(1);
        depth_lim  = (7'(max_depth) > 7'(MAX_NEST)) ? 7'(MAX_NEST) : 7'(max_depth);
        cend       = '0;
        room       = '0;

        case (eng_reg)
            ENG_EXEC:
            begin
                if (item_valid && room_for_two)
                begin
                    item_take = 1'b1;
                    // restart on the first byte of a message
                    if (item.first)
                    begin
                        total_next = (item.message_length == 32'd0) ? 32'd1
                                                                    : item.message_length;
                        pos_next   = '0;
                        nest_next  = '0;
                        err_next   = 1'b0;
                        tag_next   = '0;
                        tcnt_next  = '0;
                        cons_next  = 1'b0;
                        len_next   = '0;
                        lleft_next = '0;
                        vend_next  = total_next;
                        phase_next = (depth_lim == 7'd0) ? PH_SKIP : PH_START;
                    end
                    if (phase_next != PH_IDLE)
                    begin
                        pos_next = pos_next + 32'd1;
                        cend     = (nest_next != '0) ? top_reg : total_next;
                        room     = cend - pos_next;
                        case (phase_next)
                            PH_START:
                            begin
                                if (!item.is_pad)
                                begin
                                    cons_next  = (b & CONS_BIT) != 8'd0;
                                    tag_next   = 32'(b);
                                    tcnt_next  = '0;
                                    phase_next = item.is_tag_esc ? PH_TAG : PH_LEN1;
                                end
                            end
                            PH_TAG:
                            begin
                                if (tcnt_next >= TAG_CONT_MAX)
                                begin
                                    res[n[0]].kind       = KIND_ERROR;
                                    res[n[0]].error_code = ERR_TAG_LONG;
                                    n          = n + 2'd1;
                                    err_next   = 1'b1;
                                    phase_next = PH_HALT;
                                end
                                else
                                begin
                                    tcnt_next = tcnt_next + 2'd1;
                                    tag_next  = {tag_next[23:0], b};
                                    if (!b[7])
                                        phase_next = PH_LEN1;
                                end
                            end
                            PH_LEN1:
                            begin
                                if (b < LEN_LONG)
                                begin
                                    len_next = LW'(b);
                                    hdone    = 1'b1;
                                end
                                else if (b == LEN_LONG || 32'(cnt) > 32'(LENGTH_BYTES_MAX)
                                         || 32'(cnt) > room)
                                begin
                                    res[n[0]].kind       = KIND_ERROR;
                                    res[n[0]].error_code =
                                        (b == LEN_LONG) ? ERR_INDEF_LEN :
                                        (32'(cnt) > 32'(LENGTH_BYTES_MAX)) ? ERR_LEN_BYTES
                                                                           : ERR_TRUNCATED;
                                    n          = n + 2'd1;
                                    err_next   = 1'b1;
                                    phase_next = PH_HALT;
                                end
                                else
                                begin
                                    len_next   = '0;
                                    lleft_next = BW'(cnt);
                                    phase_next = PH_LENX;
                                end
                            end
                            PH_LENX:
                            begin
                                if (LW > 8)
                                    len_next = LW'({len_next, b});
                                else
                                    len_next = LW'(b);
                                if (lleft_next != '0)
                                    lleft_next = lleft_next - BW'(1);
                                if (lleft_next == '0)
                                    hdone = 1'b1;
                            end
                            PH_VALUE:
                            begin
                                res[n[0]].kind      = KIND_VALUE;
                                res[n[0]].depth     = 5'(nest_next);
                                res[n[0]].data_byte = b;
                                n = n + 2'd1;
                                if (pos_next == vend_next)
                                    phase_next = PH_START;
                            end
                            PH_SKIP:
                            begin
                                if (pos_next == vend_next)
                                    phase_next = PH_START;
                            end
                            default:
                            begin
                            end
                        endcase

                        // header complete: fit check, emit, then value phase, skip or descend
                        if (hdone)
                        begin
                            if (CW'(len_next) > CW'(room))
                            begin
                                vend_next  = cend;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                res[n[0]].kind         = KIND_HEADER;
                                res[n[0]].tag          = tag_next;
                                res[n[0]].constructed  = cons_next;
                                res[n[0]].value_length = 32'(len_next);
                                res[n[0]].depth        = 5'(nest_next);
                                n         = n + 2'd1;
                                vend_next = pos_next + 32'(len_next);
                                if (!cons_next)
                                    phase_next = PH_VALUE;
                                else if (7'(nest_next) + 7'd1 >= depth_lim
                                         || nest_next >= NW'(MAX_NEST))
                                    phase_next = PH_SKIP;
                                else
                                begin
                                    st_we      = 1'b1;
                                    st_waddr   = IW'(nest_next);
                                    top_next   = vend_next;
                                    nest_next  = nest_next + NW'(1);
                                    phase_next = PH_START;
                                end
                            end
                            if ((phase_next == PH_VALUE || phase_next == PH_SKIP)
                                && pos_next == vend_next)
                                phase_next = PH_START;
                        end
                        else if ((phase_next == PH_TAG || phase_next == PH_LEN1
                                  || phase_next == PH_LENX) && pos_next == cend)
                        begin
                            res[n[0]].kind       = KIND_ERROR;
                            res[n[0]].error_code = ERR_TRUNCATED;
                            n          = n + 2'd1;
                            err_next   = 1'b1;
                            phase_next = PH_HALT;
                        end

                        // end of message, else close finished containers
                        if (pos_next == total_next)
                        begin
                            res[n[0]].kind   = KIND_END;
                            res[n[0]].failed = err_next;
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else if (phase_next == PH_START)
                            eng_next = ENG_POP_TEST;
                    end
                    if (n != 2'd0)
                        res[n[0] ^ 1'b1].last_of_run = 1'b1;
                end
            end
            ENG_POP_TEST:
            begin
                if (nest_reg != '0 && top_reg == pos_reg)
                begin
                    nest_next = nest_dec;
                    if (nest_dec != '0)
                    begin
                        rd_addr  = IW'(nest_dec - NW'(1));
                        eng_next = ENG_POP_WAIT;
                    end
                    else
                        eng_next = ENG_EXEC;
                end
                else
                    eng_next = ENG_EXEC;
            end
            ENG_POP_WAIT:
            begin
                top_next = rd_data_reg;
                eng_next = ENG_POP_TEST;
            end
            default:
                eng_next = ENG_EXEC;
        endcase
    end

    assign wr_count = n;
    assign wr_res0  = res[0];
    assign wr_res1  = res[1];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg   <= ENG_EXEC;
            phase_reg <= PH_IDLE;
            tag_reg   <= '0;
            tcnt_reg  <= '0;
            cons_reg  <= 1'b0;
            len_reg   <= '0;
            lleft_reg <= '0;
            pos_reg   <= '0;
            total_reg <= '0;
            vend_reg  <= '0;
            nest_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            eng_reg   <= eng_next;
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            tcnt_reg  <= tcnt_next;
            cons_reg  <= cons_next;
            len_reg   <= len_next;
            lleft_reg <= lleft_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            vend_reg  <= vend_next;
            nest_reg  <= nest_next;
            err_reg   <= err_next;
        end
    end

    // cached stack top and container end stack memory
    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        rd_data_reg <= stack_mem[rd_addr];
        if (st_we)
            stack_mem[st_waddr] <= vend_next;
    end

endmodule

// ===== design/ber_tlv_stream_parser.sv =====
// ber_tlv_stream_parser: top level of the ber-tlv stream parser
// depends on btlv_pkg, btlv_front, btlv_back, btlv_out_queue
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  input     in         push / full             byte_value, first, message_length
//  result    out        empty / pop             kind, tag, constructed, value_length,
//                                               depth, data_byte, error_code, failed,
//                                               last_of_run
//  config    in         cfg_valid / cfg_ready   cfg_data (max_depth)
//
//  a byte that leaves the parse at an element start (and does not end the message)
//  sends the engine to test the stack top; each nesting level closed on it adds
//  a stack read and another test, except a close back to depth 0
//  reset clears all control state and sets max_depth to 32
//  a two-entry input queue and a four-entry result queue let either side stall
//  the engine waits for room for two results before taking a byte

module ber_tlv_stream_parser #(
    parameter int MAX_NEST         = 32,
    parameter int LENGTH_BYTES_MAX = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        first,
    input  logic [31:0] message_length,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] tag,
    output logic        constructed,
    output logic [31:0] value_length,
    output logic [4:0]  depth,
    output logic [7:0]  data_byte,
    output logic [1:0]  error_code,
    output logic        failed,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
    import btlv_pkg::*;

    logic [5:0] max_depth_val_reg;
    logic       item_valid, item_take, room_for_two;
    item_t      item;
    logic [1:0] wr_count;
    result_t    wr_res0, wr_res1, head;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_depth_val_reg <= MAX_DEPTH_RST;
        else if (cfg_valid && cfg_ready)
            max_depth_val_reg <= cfg_data;
    end

    btlv_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .byte_value     (byte_value),
        .first          (first),
        .message_length (message_length),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take)
    );

    btlv_back #(
        .MAX_NEST         (MAX_NEST),
        .LENGTH_BYTES_MAX (LENGTH_BYTES_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_depth    (max_depth_val_reg),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .room_for_two (room_for_two),
        .wr_count     (wr_count),
        .wr_res0      (wr_res0),
        .wr_res1      (wr_res1)
    );

    btlv_out_queue u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_count     (wr_count),
        .wr_res0      (wr_res0),
        .wr_res1      (wr_res1),
        .room_for_two (room_for_two),
        .empty        (empty),
        .pop          (pop),
        .head         (head)
    );

    // result fields
    assign kind         = head.kind;
    assign tag          = head.tag;
    assign constructed  = head.constructed;
    assign value_length = head.value_length;
    assign depth        = head.depth;
    assign data_byte    = head.data_byte;
    assign error_code   = head.error_code;
    assign failed       = head.failed;
    assign last_of_run  = head.last_of_run;

endmodule

// ===== bench/tb_ber_tlv_stream_parser.sv =====
// tb_ber_tlv_stream_parser: self-checking bench for the ber-tlv stream parser
// depends on btlv_pkg and ber_tlv_stream_parser; predicts every result in-bench
`timescale 1ns / 1ps

module tb_ber_tlv_stream_parser;
    import btlv_pkg::*;

    localparam int NEST_LIM = 32;
    localparam int LEN_MAX  = 4;

    typedef struct {
        logic [7:0]  b;
        logic        first;
        logic [31:0] mlen;
        logic        is_cfg;
        logic [5:0]  cfg;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  byte_value = '0;
    logic        first = 1'b0;
    logic [31:0] message_length = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [31:0] tag;
    logic        constructed;
    logic [31:0] value_length;
    logic [4:0]  depth;
    logic [7:0]  data_byte;
    logic [1:0]  error_code;
    logic        failed;
    logic        last_of_run;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;

    ber_tlv_stream_parser u_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [5:0]  p_max_depth = MAX_DEPTH_RST;
    phase_t      p_phase = PH_IDLE;
    logic [31:0] p_tag;
    logic [1:0]  p_tcnt;
    logic        p_cons;
    logic [63:0] p_len;
    logic [2:0]  p_lleft;
    logic [31:0] p_pos_reg, p_total, p_vend;
    logic [31:0] p_stack [NEST_LIM];
    int          p_nest;
    logic        p_err;

    stim_t   pending_q[$];
    result_t expected_q[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    bit      quiet = 0;
    bit      in_taken = 0;
    bit      cfg_taken = 0;

    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic result_t blank(input logic [1:0] k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // compute the results caused by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic f, input logic [31:0] ml);
        int          lim;
        logic [31:0] pos, cend;
        bit          hdone;
        int          cnt;
        result_t     r;
        result_t     outs[$];
        lim = p_max_depth > NEST_LIM ? NEST_LIM : p_max_depth;
        hdone = 0;
        if (f) begin
            p_total = ml == 0 ? 32'd1 : ml;
            p_pos_reg = 0; p_nest = 0; p_err = 0; p_tag = 0; p_tcnt = 0;
            p_cons = 0; p_len = 0; p_lleft = 0; p_vend = p_total;
            p_phase = lim == 0 ? PH_SKIP : PH_START;
        end
        if (p_phase == PH_IDLE)
            return;
        pos = p_pos_reg + 1;
        p_pos_reg = pos;
        cend = p_nest > 0 ? p_stack[p_nest - 1] : p_total;
        case (p_phase)
            PH_START:
                if (b != PAD_ZERO && b != PAD_ONES) begin
                    p_cons = (b & CONS_BIT) != 0;
                    p_tag = 32'(b);
                    p_tcnt = 0;
                    p_phase = (b & TAG_ESC_MASK) == TAG_ESC_MASK ? PH_TAG : PH_LEN1;
                end
            PH_TAG:
                if (p_tcnt >= TAG_CONT_MAX) begin
                    r = blank(KIND_ERROR); r.error_code = ERR_TAG_LONG; outs = {outs, r};
                    p_err = 1; p_phase = PH_HALT;
                end else begin
                    p_tcnt++;
                    p_tag = {p_tag[23:0], b};
                    if (!b[7]) p_phase = PH_LEN1;
                end
            PH_LEN1:
                if (b < LEN_LONG) begin
                    p_len = 64'(b); hdone = 1;
                end else if (b == LEN_LONG) begin
                    r = blank(KIND_ERROR); r.error_code = ERR_INDEF_LEN; outs = {outs, r};
                    p_err = 1; p_phase = PH_HALT;
                end else begin
                    cnt = b & LEN_CNT_MASK;
                    if (cnt > LEN_MAX) begin
                        r = blank(KIND_ERROR); r.error_code = ERR_LEN_BYTES; outs = {outs, r};
                        p_err = 1; p_phase = PH_HALT;
                    end else if (cnt > cend - pos) begin
                        r = blank(KIND_ERROR); r.error_code = ERR_TRUNCATED; outs = {outs, r};
                        p_err = 1; p_phase = PH_HALT;
                    end else begin
                        p_len = 0; p_lleft = 3'(cnt); p_phase = PH_LENX;
                    end
                end
            PH_LENX: begin
                p_len = {p_len[55:0], b};
                if (p_lleft > 0) p_lleft--;
                if (p_lleft == 0) hdone = 1;
            end
            PH_VALUE: begin
                r = blank(KIND_VALUE); r.depth = p_nest[4:0]; r.data_byte = b;
                outs = {outs, r};
                if (pos == p_vend) p_phase = PH_START;
            end
            PH_SKIP:
                if (pos == p_vend) p_phase = PH_START;
            default: ;
        endcase
        if (hdone) begin
            if (p_len > 64'(cend - pos)) begin
                p_vend = cend; p_phase = PH_SKIP;
            end else begin
                r = blank(KIND_HEADER);
                r.tag = p_tag; r.constructed = p_cons;
                r.value_length = p_len[31:0]; r.depth = p_nest[4:0];
                outs = {outs, r};
                p_vend = pos + p_len[31:0];
                if (!p_cons) p_phase = PH_VALUE;
                else if (p_nest + 1 >= lim || p_nest >= NEST_LIM) p_phase = PH_SKIP;
                else begin
                    p_stack[p_nest] = p_vend; p_nest++; p_phase = PH_START;
                end
            end
            if ((p_phase == PH_VALUE || p_phase == PH_SKIP) && pos == p_vend)
                p_phase = PH_START;
        end else if ((p_phase == PH_TAG || p_phase == PH_LEN1 || p_phase == PH_LENX)
                     && pos == cend) begin
            r = blank(KIND_ERROR); r.error_code = ERR_TRUNCATED; outs = {outs, r};
            p_err = 1; p_phase = PH_HALT;
        end
        if (p_phase == PH_START)
            while (p_nest > 0 && p_stack[p_nest - 1] == pos) p_nest--;
        if (pos == p_total) begin
            r = blank(KIND_END); r.failed = p_err; outs = {outs, r};
            p_phase = PH_IDLE;
        end
        if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
        expected_q = {expected_q, outs};
    endtask

    // stimulus builders
    task automatic add(input logic [7:0] b, input logic f = 0, input logic [31:0] ml = 0);
        stim_t s;
        s.b = b; s.first = f; s.mlen = ml; s.is_cfg = 0; s.cfg = 0;
        pending_q = {pending_q, s};
    endtask

    task automatic add_cfg(input logic [5:0] v);
        stim_t s;
        s = '{default: '0};
        s.is_cfg = 1; s.cfg = v;
        pending_q = {pending_q, s};
    endtask

    task automatic add_msg(input logic [7:0] m[$]);
        foreach (m[i]) add(m[i], i == 0, 32'(m.size()));
    endtask

    // random well-formed element into m, at nesting lvl
    task automatic gen_elem(ref logic [7:0] m[$], input int lvl);
        logic [7:0] body[$];
        int         n, ntag, k;
        bit         cons;
        cons = lvl < 6 && $urandom_range(0, 2) == 0;
        if ($urandom_range(0, 4) == 0)
            m = {m, ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF};
        if (cons) begin
            n = $urandom_range(0, 3);
            repeat (n) gen_elem(body, lvl + 1);
        end else begin
            n = $urandom_range(0, 5);
            repeat (n) body = {body, 8'($urandom)};
        end
        if ($urandom_range(0, 3) == 0) begin
            m = {m, {3'($urandom_range(0, 7)), 5'h1F} | (cons ? 8'h20 : 8'h00)};
            ntag = $urandom_range(1, 3);
            for (k = 0; k < ntag; k++)
                m = {m, (k < ntag - 1) ? (8'($urandom) | 8'h80) : (8'($urandom) & 8'h7F)};
        end else begin
            m = {m, ({3'($urandom_range(0, 7)), 5'($urandom_range(1, 30))}
                     & (cons ? 8'hFF : 8'hDF)) | (cons ? 8'h20 : 8'h00)};
        end
        k = $urandom_range(0, 3);
        if (body.size() < 128 && k == 0) m = {m, 8'(body.size())};
        else if (k == 3)
            m = {m, 8'h84, 8'h00, 8'h00, 8'h00, 8'(body.size())};
        else
            m = {m, 8'h82, 8'(body.size() >> 8), 8'(body.size())};
        m = {m, body};
    endtask

    // driver: one transaction per cycle when free, with random gaps outside quiet mode
    always @(negedge clk) begin
        logic nxt_cfg_valid;
        logic nxt_push;
        if (rst_n) begin
            // hold a transaction that was not taken at the last rising edge
            nxt_cfg_valid = cfg_valid && !cfg_taken;
            nxt_push      = push && !in_taken;
            if (!nxt_cfg_valid && !nxt_push && pending_q.size() > 0
                && (quiet || $urandom_range(0, 99) >= 14)) begin
                if (pending_q[0].is_cfg) begin
                    if (expected_q.size() == 0 && !push) begin
                        nxt_cfg_valid = 1'b1;
                        cfg_data <= pending_q[0].cfg;
                    end
                end else begin
                    nxt_push = 1'b1;
                    byte_value <= pending_q[0].b;
                    first <= pending_q[0].first;
                    message_length <= pending_q[0].mlen;
                end
            end
            cfg_valid <= nxt_cfg_valid;
            push <= nxt_push;
            pop <= quiet || $urandom_range(0, 99) >= 14;
        end
    end

    // predictor feed and config tracking
    always @(posedge clk) begin
        in_taken  = push && !full;
        cfg_taken = cfg_valid && cfg_ready;
        if (in_taken) begin
            predict_byte(byte_value, first, message_length);
            void'(pending_q.pop_front());
            items_sent++;
        end
        if (cfg_taken) begin
            p_max_depth = cfg_data;
            void'(pending_q.pop_front());
        end
    end

    // monitor
    always @(posedge clk) begin
        result_t e;
        if (rst_n && pop && !empty) begin
            results_seen++;
            if (expected_q.size() == 0)
                report($sformatf("unexpected result kind %0d", kind));
            else begin
                e = expected_q.pop_front();
                if (kind != e.kind) report($sformatf("kind %0d exp %0d", kind, e.kind));
                if (tag != e.tag) report($sformatf("tag %h exp %h", tag, e.tag));
                if (constructed != e.constructed) report("constructed differs");
                if (value_length != e.value_length)
                    report($sformatf("value_length %0d exp %0d", value_length, e.value_length));
                if (depth != e.depth) report($sformatf("depth %0d exp %0d", depth, e.depth));
                if (data_byte != e.data_byte)
                    report($sformatf("data_byte %h exp %h", data_byte, e.data_byte));
                if (error_code != e.error_code)
                    report($sformatf("error_code %0d exp %0d", error_code, e.error_code));
                if (failed != e.failed) report("failed differs");
                if (last_of_run != e.last_of_run) report("last_of_run differs");
            end
        end
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [7:0] m[$];
        int         depths[4];
        int         d;
        depths = '{32, 1, 2, 63};
        // directed: padding, primitive, constructed, long tag/len, errors
        add_msg('{8'h00, 8'hFF, 8'h04, 8'h01, 8'hAB});
        add_msg('{8'h30, 8'h03, 8'h02, 8'h01, 8'h7F, 8'h00});
        add_msg('{8'h5F, 8'h81, 8'h82, 8'h03, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55});
        add_msg('{8'h1F, 8'h81, 8'h82, 8'h83, 8'h04});
        add_msg('{8'h04, 8'h80, 8'h11});
        add_msg('{8'h04, 8'h85, 8'h11});
        add_msg('{8'h04, 8'h83, 8'h11});
        add_msg('{8'h04, 8'h05, 8'h11, 8'h22});
        add_msg('{8'h30, 8'h02, 8'h1F, 8'h81, 8'h01});
        add(8'h12, 1'b1, 32'd0);
        add(8'h77);
        add(8'h04, 1'b1, 32'hFFFFFFFF);
        add(8'h04, 1'b1, 32'd3);
        add(8'hFF); add(8'h00);
        for (int ph = 0; ph < 4; ph++) begin
            add_cfg(6'(depths[ph]));
            add_msg('{8'h30, 8'h05, 8'h30, 8'h03, 8'h04, 8'h01, 8'hEE});
            add_cfg(6'd0);
            add_msg('{8'h04, 8'h01, 8'h22});
        end
        // random part, depth setting changes between phases
        for (int ph = 0; ph < 6; ph++) begin
            d = ph == 5 ? int'(MAX_DEPTH_RST) : int'($urandom_range(1, 40));
            add_cfg(6'(d));
            while (pending_q.size() < 325 * (ph + 1)) begin
                m.delete();
                repeat ($urandom_range(1, 3)) gen_elem(m, 0);
                if ($urandom_range(0, 7) == 0)
                    m[$urandom_range(0, m.size() - 1)] = 8'($urandom);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) void'(m.pop_back());
                if (m.size() == 0) m = {m, 8'($urandom)};
                add_msg(m);
                if ($urandom_range(0, 15) == 0) add(8'($urandom));
            end
        end
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        #15us quiet = 1;
        #20us quiet = 0;
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (100) @(posedge clk);
        $display("Sent %0d bytes over several max_depth settings; checked %0d results.",
                 items_sent, results_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
